// ===== hdl/leja_point_ordering_core_assert.svh =====
// Assertion macros for the Leja point ordering core.
`ifndef LEJA_POINT_ORDERING_CORE_ASSERT_SVH
`define LEJA_POINT_ORDERING_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LPO_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LPO_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ===== hdl/lpo_pkg.sv =====
// ----------------------------------------------------------------------------
// lpo_pkg
// Shared constants and types of the Leja point ordering core.
// ----------------------------------------------------------------------------
`default_nettype none
package lpo_pkg;
   localparam int unsigned CoordWidth = 24;
   localparam int unsigned ProdWidth  = 64;
   localparam int unsigned DistWidth  = 26;
   localparam int unsigned SumWidth   = 51;
   localparam int unsigned DMaxDefault = 16;
   localparam logic [ProdWidth-1:0] OneQ16 = 64'd65536;

   // Control from the sequencer to the serial arithmetic units.
   typedef struct packed {
      logic sqrt_start;
      logic mul_start;
   } unit_ctrl_type;
endpackage
`default_nettype wire

// ===== hdl/leja_point_ordering_core.sv =====
// ----------------------------------------------------------------------------
// leja_point_ordering_core
// Loads complex points and emits them in greedy Leja order.
// ----------------------------------------------------------------------------
// Usage: raise start with a point while busy is low; each point takes
// one transaction. A point with req_last_point closes the set and starts the
// ordering; busy stays high until the last result is out. Points beyond
// D_MAX are dropped. Results appear spaced apart on the rsp_ ports, each
// marked by rsp_valid for exactly one cycle; rsp_last_out marks the final one.
// The receiver cannot stall, so results are never held.
// Loading accepts one point per cycle. Ordering runs n-1 steps; each
// step walks the remaining points through one serial distance unit (square
// steps, root steps and rounding) and one serial multiplier, plus a read
// and a write-back, then reads slot i and swaps the best point into it.
// Emission then reads the points out in order.
// Reset clears the point count and the sequencer; memory contents are not
// cleared because only loaded entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "leja_point_ordering_core_assert.svh"
module leja_point_ordering_core
   import lpo_pkg::*;
#(
   parameter int unsigned D_MAX = DMaxDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [CoordWidth-1:0] req_point_re,
   input  wire logic signed [CoordWidth-1:0] req_point_im,
   input  wire logic                         req_last_point,
   output logic                              rsp_valid,
   output logic signed [CoordWidth-1:0]      rsp_ordered_re,
   output logic signed [CoordWidth-1:0]      rsp_ordered_im,
   output logic                              rsp_last_out
);
   localparam int unsigned AW = $clog2(D_MAX);
   localparam int unsigned CW = $clog2(D_MAX + 1);
   localparam int unsigned PW = 2 * CoordWidth;

   typedef enum logic [3:0] {
      S_LOAD, S_RD, S_RDW, S_DIST, S_MUL, S_WR, S_RDB, S_RDBW, S_SWAP,
      S_OUT, S_OUTW
   } state_type;

   state_type       state_ff;
   logic [CW-1:0]   count_ff, i_ff, j_ff;
   logic [AW-1:0]   best_ff;
   logic [ProdWidth-1:0] best_p_ff;
   logic [PW-1:0]   ref_ff, cur_pt_ff;
   logic [ProdWidth-1:0] cur_p_ff;
   logic            fix_ff;
   logic [PW-1:0]   bpt_ff;
   logic [ProdWidth-1:0] bpr_ff;

   logic            pt_we, pr_we;
   logic [AW-1:0]   pt_addr, pr_addr;
   logic [PW-1:0]   pt_wd, pt_rd;
   logic [ProdWidth-1:0] pr_wd, pr_rd;
   unit_ctrl_type   ctrl;
   logic            sq_done, mu_done;
   logic [DistWidth-1:0] distance;
   logic [ProdWidth-1:0] mu_res;
   logic            accept;

   assign accept = start && !busy;
   assign busy = (state_ff != S_LOAD);

   lpo_ram #(.Width(PW), .Depth(D_MAX)) u_pt (
      .clock(clock), .wr_en(pt_we), .addr(pt_addr), .wr_data(pt_wd), .rd_data(pt_rd));
   lpo_ram #(.Width(ProdWidth), .Depth(D_MAX)) u_pr (
      .clock(clock), .wr_en(pr_we), .addr(pr_addr), .wr_data(pr_wd), .rd_data(pr_rd));

   lpo_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(ctrl.sqrt_start),
      .a_re(pt_rd[PW-1:CoordWidth]), .a_im(pt_rd[CoordWidth-1:0]),
      .b_re(ref_ff[PW-1:CoordWidth]), .b_im(ref_ff[CoordWidth-1:0]),
      .done(sq_done), .distance(distance));
   lpo_mul u_mul (
      .clock(clock), .reset(reset), .start(ctrl.mul_start), .prod(cur_p_ff),
      .distance(distance), .done(mu_done), .result(mu_res));

   assign ctrl.sqrt_start = (state_ff == S_RDW);
   assign ctrl.mul_start  = (state_ff == S_DIST) && sq_done;

   // Memory port control, one access per cycle on each port.
   always_comb begin
      pt_we   = 1'b0;
      pr_we   = 1'b0;
      pt_addr = j_ff[AW-1:0];
      pr_addr = j_ff[AW-1:0];
      pt_wd   = cur_pt_ff;
      pr_wd   = mu_res;
      unique case (state_ff)
         S_LOAD: begin
            pt_addr = count_ff[AW-1:0];
            pr_addr = count_ff[AW-1:0];
            pt_we   = accept && (count_ff < CW'(D_MAX));
            pr_we   = pt_we;
            pt_wd   = {req_point_re, req_point_im};
            pr_wd   = OneQ16;
         end
         S_WR: pr_we = 1'b1;
         S_SWAP: begin
            // Old slot i goes to best first, then best's entry goes to slot i.
            pt_addr = fix_ff ? i_ff[AW-1:0] : best_ff;
            pr_addr = fix_ff ? i_ff[AW-1:0] : best_ff;
            pt_we   = 1'b1;
            pr_we   = 1'b1;
            pt_wd   = fix_ff ? bpt_ff : cur_pt_ff;
            pr_wd   = fix_ff ? bpr_ff : cur_p_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         rsp_valid <= 1'b0;
         fix_ff   <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         fix_ff    <= 1'b0;
         unique case (state_ff)
            S_LOAD: begin
               if (accept) begin
                  if (count_ff < CW'(D_MAX)) count_ff <= count_ff + CW'(1);
                  if (req_last_point) begin
                     ref_ff <= '0;
                     i_ff   <= '0;
                     j_ff   <= '0;
                     best_p_ff <= '0;
                     state_ff <= ((count_ff < CW'(D_MAX) ? count_ff + CW'(1) : count_ff)
                                  > CW'(1)) ? S_RD : S_OUT;
                  end
               end
            end
            S_RD: state_ff <= S_RDW;
            S_RDW: begin
               cur_pt_ff <= pt_rd;
               cur_p_ff  <= pr_rd;
               state_ff  <= S_DIST;
            end
            S_DIST: if (sq_done) state_ff <= S_MUL;
            S_MUL: if (mu_done) state_ff <= S_WR;
            S_WR: begin
               if (j_ff == i_ff || mu_res > best_p_ff) begin
                  best_ff   <= j_ff[AW-1:0];
                  best_p_ff <= mu_res;
                  bpt_ff    <= cur_pt_ff;
                  bpr_ff    <= mu_res;
               end
               if (j_ff + CW'(1) == count_ff) begin
                  j_ff     <= i_ff;
                  state_ff <= S_RDB;
               end else begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_RD;
               end
            end
            S_RDB: state_ff <= S_RDBW;
            S_RDBW: begin
               // Slot i (j_ff holds i) is held for the first swap write.
               cur_pt_ff <= pt_rd;
               cur_p_ff  <= pr_rd;
               state_ff  <= S_SWAP;
            end
            S_SWAP: begin
               fix_ff   <= 1'b1;
               ref_ff   <= bpt_ff;
               state_ff <= S_SWAP;
               if (fix_ff) begin
                  if (i_ff + CW'(2) == count_ff) begin
                     i_ff <= '0;
                     j_ff <= '0;
                     state_ff <= S_OUT;
                  end else begin
                     i_ff <= i_ff + CW'(1);
                     j_ff <= i_ff + CW'(1);
                     best_p_ff <= '0;
                     state_ff <= S_RD;
                  end
               end
            end
            S_OUT: state_ff <= S_OUTW;
            S_OUTW: begin
               rsp_valid      <= 1'b1;
               rsp_ordered_re <= pt_rd[PW-1:CoordWidth];
               rsp_ordered_im <= pt_rd[CoordWidth-1:0];
               rsp_last_out   <= (j_ff + CW'(1) == count_ff);
               if (j_ff + CW'(1) == count_ff) begin
                  count_ff <= '0;
                  state_ff <= S_LOAD;
               end else begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_OUT;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   `LPO_ASSERT_IMP(a_mid_rsp_busy, clock, reset, rsp_valid && !rsp_last_out, busy)
   `LPO_ASSERT_IMP(a_last_idle, clock, reset, rsp_valid && rsp_last_out, !busy && count_ff == '0)
   `LPO_ASSERT_NEXT(a_rsp_spaced, clock, reset, rsp_valid && !rsp_last_out, !rsp_valid)
   `LPO_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(D_MAX))
endmodule
`default_nettype wire

// ===== hdl/lpo_ram.sv =====
// ----------------------------------------------------------------------------
// lpo_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lpo_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== hdl/lpo_sqrt.sv =====
// ----------------------------------------------------------------------------
// lpo_sqrt
// Distance unit: serial squares and a rounded square root, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lpo_sqrt
   import lpo_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [CoordWidth-1:0] a_re,
   input  wire logic signed [CoordWidth-1:0] a_im,
   input  wire logic signed [CoordWidth-1:0] b_re,
   input  wire logic signed [CoordWidth-1:0] b_im,
   output logic                              done,
   output logic [DistWidth-1:0]              distance
);
   localparam int unsigned DiffWidth = CoordWidth + 1;
   localparam int unsigned RemWidth  = DistWidth + 3;

   typedef enum logic [1:0] {S_IDLE, S_SQX, S_SQY, S_ROOT} state_type;

   state_type             state_ff;
   logic [4:0]            cnt_ff;
   logic [DiffWidth-1:0]  ux_ff, uy_ff, mshift_ff;
   logic [SumWidth-1:0]   acc_ff;
   logic [SumWidth+1:0]   rad_ff;
   logic [RemWidth-1:0]   rem_ff;
   logic [DistWidth-1:0]  root_ff;
   logic                  done_ff;

   logic signed [DiffWidth-1:0] dx, dy;
   logic [RemWidth-1:0]         trial, rem_sh;

   assign dx = DiffWidth'(a_re) - DiffWidth'(b_re);
   assign dy = DiffWidth'(a_im) - DiffWidth'(b_im);
   // The radicand is below 2^50, so the first digit pair sits at bits 51:50.
   assign rem_sh = {rem_ff[RemWidth-3:0], rad_ff[SumWidth:SumWidth-1]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  ux_ff     <= dx[DiffWidth-1] ? -dx : dx;
                  uy_ff     <= dy[DiffWidth-1] ? -dy : dy;
                  mshift_ff <= dx[DiffWidth-1] ? -dx : dx;
                  acc_ff    <= '0;
                  cnt_ff    <= '0;
                  state_ff  <= S_SQX;
               end
            end
            S_SQX, S_SQY: begin
               // Shift-add multiply, one multiplier bit per cycle; the last
               // step is folded into the radicand update.
               if (cnt_ff == 5'(DiffWidth-1)) begin
                  cnt_ff <= '0;
                  if (state_ff == S_SQX) begin
                     rad_ff    <= {2'b00, acc_ff[SumWidth-2:0], 1'b0} +
                                  (mshift_ff[0] ? (SumWidth+2)'(ux_ff) : '0);
                     mshift_ff <= uy_ff;
                     acc_ff    <= '0;
                     state_ff  <= S_SQY;
                  end else begin
                     rad_ff   <= rad_ff + {1'b0, acc_ff, 1'b0} +
                                 (mshift_ff[0] ? (SumWidth+2)'(uy_ff) : '0);
                     rem_ff   <= '0;
                     root_ff  <= '0;
                     state_ff <= S_ROOT;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
                  if (mshift_ff[DiffWidth-1 - cnt_ff]) begin
                     acc_ff <= (acc_ff << 1) +
                               SumWidth'(state_ff == S_SQX ? ux_ff : uy_ff);
                  end else begin
                     acc_ff <= acc_ff << 1;
                  end
               end
            end
            S_ROOT: begin
               // Restoring root, two radicand bits per cycle.
               rad_ff <= rad_ff << 2;
               if (rem_sh >= trial) begin
                  rem_ff  <= rem_sh - trial;
                  root_ff <= {root_ff[DistWidth-2:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  root_ff <= {root_ff[DistWidth-2:0], 1'b0};
               end
               if (cnt_ff == 5'(DistWidth-1)) begin
                  state_ff <= S_IDLE;
                  done_ff  <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Rounding: the remainder exceeds the root exactly when the true root
   // lies above the half point, done in the cycle after the last step.
   logic [DistWidth-1:0] dist_ff;
   logic                 dv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
      end else begin
         dv_ff <= done_ff;
      end
      if (done_ff) begin
         dist_ff <= root_ff + DistWidth'(rem_ff > RemWidth'(root_ff));
      end
   end
   assign done     = dv_ff;
   assign distance = dist_ff;
endmodule
`default_nettype wire

// ===== hdl/lpo_mul.sv =====
// ----------------------------------------------------------------------------
// lpo_mul
// Product update unit: serial (product * distance) >> 16 with saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module lpo_mul
   import lpo_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [ProdWidth-1:0] prod,
   input  wire logic [DistWidth-1:0] distance,
   output logic                      done,
   output logic [ProdWidth-1:0]      result
);
   localparam int unsigned AccWidth = ProdWidth + DistWidth;

   logic                 busy_ff, done_ff;
   logic [4:0]           cnt_ff;
   logic [ProdWidth-1:0] p_ff;
   logic [DistWidth-1:0] d_ff;
   logic [AccWidth-1:0]  acc_ff;
   logic [AccWidth-1:0]  acc_in;

   // Distance bits enter from the top, one per cycle.
   assign acc_in = (acc_ff << 1) + (d_ff[DistWidth-1] ? AccWidth'(p_ff) : '0);

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         p_ff    <= prod;
         d_ff    <= distance;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         d_ff   <= d_ff << 1;
         if (cnt_ff == 5'(DistWidth-1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff + 5'd1;
         end
      end
   end

   assign done = done_ff;
   assign result = (|acc_ff[AccWidth-1:ProdWidth+16]) ? '1 : acc_ff[ProdWidth+15:16];
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Leja point ordering core. Point sets are loaded
// through the command port; a model in the bench orders each set greedily in
// fixed point and the emitted points are compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top
   import lpo_pkg::*;
();

   localparam int unsigned SetMax   = 16;
   localparam int unsigned IdleLimit = 400000;

   typedef struct {
      logic signed [CoordWidth-1:0] re;
      logic signed [CoordWidth-1:0] im;
      logic                         last;
   } leja_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CoordWidth-1:0] req_point_re = '0;
   logic signed [CoordWidth-1:0] req_point_im = '0;
   logic req_last_point = 1'b0;
   logic rsp_valid;
   logic signed [CoordWidth-1:0] rsp_ordered_re;
   logic signed [CoordWidth-1:0] rsp_ordered_im;
   logic rsp_last_out;

   leja_point_type ordered_q[$];
   logic signed [CoordWidth-1:0] set_re[SetMax];
   logic signed [CoordWidth-1:0] set_im[SetMax];
   int unsigned set_count = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   leja_point_ordering_core #(.D_MAX(SetMax)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point_re(req_point_re), .req_point_im(req_point_im),
      .req_last_point(req_last_point), .rsp_valid(rsp_valid),
      .rsp_ordered_re(rsp_ordered_re), .rsp_ordered_im(rsp_ordered_im),
      .rsp_last_out(rsp_last_out)
   );

   function automatic logic [63:0] round_sqrt(logic [63:0] s);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      // s now holds the remainder; round to nearest.
      if (s > r) r = r + 1;
      return r;
   endfunction

   function automatic logic [63:0] dist_q16(logic signed [CoordWidth-1:0] ar,
         logic signed [CoordWidth-1:0] ai, logic signed [CoordWidth-1:0] br,
         logic signed [CoordWidth-1:0] bi);
      logic signed [25:0] dx;
      logic signed [25:0] dy;
      logic [63:0] ux;
      logic [63:0] uy;
      dx = 26'(ar) - 26'(br);
      dy = 26'(ai) - 26'(bi);
      ux = dx < 0 ? 64'(-dx) : 64'(dx);
      uy = dy < 0 ? 64'(-dy) : 64'(dy);
      return round_sqrt(ux * ux + uy * uy);
   endfunction

   function automatic logic [63:0] scale_product(logic [63:0] p, logic [63:0] d);
      logic [127:0] full;
      full = (128'(p) * 128'(d)) >> 16;
      return (full[127:64] != 0) ? '1 : full[63:0];
   endfunction

   // Orders the loaded set and queues one expected point per entry.
   task automatic predict_leja_order();
      logic [63:0] prod[SetMax];
      logic signed [CoordWidth-1:0] ref_re;
      logic signed [CoordWidth-1:0] ref_im;
      logic signed [CoordWidth-1:0] t;
      logic [63:0] tp;
      int unsigned best;
      leja_point_type e;
      ref_re = 0;
      ref_im = 0;
      for (int j = 0; j < set_count; j++) prod[j] = OneQ16;
      for (int i = 0; i + 1 < set_count; i++) begin
         for (int j = i; j < set_count; j++)
            prod[j] = scale_product(prod[j], dist_q16(set_re[j], set_im[j], ref_re, ref_im));
         best = i;
         for (int j = i + 1; j < set_count; j++)
            if (prod[j] > prod[best]) best = j;
         if (best != i) begin
            t = set_re[i]; set_re[i] = set_re[best]; set_re[best] = t;
            t = set_im[i]; set_im[i] = set_im[best]; set_im[best] = t;
            tp = prod[i]; prod[i] = prod[best]; prod[best] = tp;
         end
         ref_re = set_re[i];
         ref_im = set_im[i];
      end
      for (int i = 0; i < set_count; i++) begin
         e.re = set_re[i];
         e.im = set_im[i];
         e.last = (i + 1 == set_count);
         ordered_q.push_back(e);
      end
      set_count = 0;
   endtask

   // Random gaps between bursts of transactions.
   int unsigned burst_left = 0;

   task automatic send_point(logic signed [CoordWidth-1:0] re,
         logic signed [CoordWidth-1:0] im, logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_point_re <= re;
      req_point_im <= im;
      req_last_point <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (set_count < SetMax) begin
         set_re[set_count] = re;
         set_im[set_count] = im;
         set_count++;
      end
      if (last) predict_leja_order();
   endtask

   task automatic send_set(int unsigned n);
      for (int i = 0; i < n; i++)
         send_point(CoordWidth'($urandom), CoordWidth'($urandom), i + 1 == n);
   endtask

   task automatic test_single_point();
      send_point(24'sh7FFFFF, -24'sh800000, 1'b1);
      send_point(24'sh0, 24'sh0, 1'b1);
   endtask

   task automatic test_extremes();
      send_point(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
      send_point(-24'sh800000, -24'sh800000, 1'b0);
      send_point(24'sh7FFFFF, -24'sh800000, 1'b0);
      send_point(-24'sh800000, 24'sh7FFFFF, 1'b0);
      send_point(24'sh0, 24'sh0, 1'b1);
   endtask

   task automatic test_ties();
      // Equal products must keep the lower position.
      send_point(24'sh010000, 24'sh0, 1'b0);
      send_point(-24'sh010000, 24'sh0, 1'b0);
      send_point(24'sh0, 24'sh010000, 1'b0);
      send_point(24'sh010000, 24'sh0, 1'b1);
   endtask

   task automatic test_overflow_set();
      // Seventeen points: the last one is dropped but still starts ordering.
      for (int i = 0; i < SetMax + 1; i++)
         send_point(CoordWidth'($urandom), CoordWidth'($urandom), i == SetMax);
   endtask

   task automatic test_random_sets();
      int unsigned sent;
      sent = 0;
      while (sent < 240) begin
         int unsigned n;
         n = ($urandom_range(0, 9) == 0) ? SetMax : $urandom_range(1, 6);
         send_set(n);
         sent += n;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         leja_point_type e;
         if (ordered_q.size() == 0) begin
            $display("%0t: unexpected point re=%h im=%h", $time, rsp_ordered_re,
                     rsp_ordered_im);
            error_count++;
         end else begin
            e = ordered_q.pop_front();
            if (rsp_ordered_re !== e.re) begin
               $display("%0t: re expected %h actual %h", $time, e.re, rsp_ordered_re);
               error_count++;
            end
            if (rsp_ordered_im !== e.im) begin
               $display("%0t: im expected %h actual %h", $time, e.im, rsp_ordered_im);
               error_count++;
            end
            if (rsp_last_out !== e.last) begin
               $display("%0t: last expected %b actual %b", $time, e.last, rsp_last_out);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted transaction or valid result.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_point();
      test_extremes();
      test_ties();
      test_overflow_set();
      test_random_sets();
      start <= 1'b0;
      while (ordered_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
